@@ rtl/core/calendar_date_span_core_assert.svh @@
// Assertion macros shared by the calendar date span core.
`ifndef CALENDAR_DATE_SPAN_CORE_ASSERT_SVH
`define CALENDAR_DATE_SPAN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled while aresetn is low.
`define CDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while aresetn is low.
`define CDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cds_pkg.sv @@
// Types, constants and calendar lookup functions for the calendar date span core.
`default_nettype none

package cds_pkg;

    localparam int MODE_W     = 3;
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int YY_W       = 15;
    localparam int DN_W       = 23;
    localparam int SPAN_W     = 22;
    localparam int WD_W       = 3;
    localparam int MTERM_W    = 9;
    localparam int IN_BITS    = 49;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    localparam int YEAR_OFFSET  = 400;
    localparam int RECIP100     = 5243;
    localparam int RECIP100_SH  = 19;
    localparam int RECIP7       = 9586981;
    localparam int RECIP7_SH    = 26;
    localparam int SPAN_MAX     = 4194303;

    typedef enum logic [MODE_W-1:0] {
        MODE_DAYS      = 3'd0,
        MODE_INCL_DAYS = 3'd1,
        MODE_WEEKS     = 3'd2,
        MODE_MONTHS    = 3'd3,
        MODE_YEARS     = 3'd4,
        MODE_WORK_DAYS = 3'd5
    } mode_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month, with March as month zero.
    function automatic logic [MTERM_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MTERM_W-1:0] r;
        case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            default: r = 9'd337;
        endcase
        return r;
    endfunction

    // Working days among the first rest days of a week that starts on weekday wd.
    function automatic logic [2:0] work_partial(input logic [WD_W-1:0] wd,
                                                input logic [2:0] rest);
        logic [2:0] cnt;
        logic [3:0] s;
        cnt = 3'd0;
        for (int k = 0; k < 6; k++) begin
            s = 4'(wd) + 4'(k);
            if (s >= 4'd7) begin
                s = s - 4'd7;
            end
            if ((3'(k) < rest) && (s < 4'd5)) begin
                cnt = cnt + 3'd1;
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/calendar_date_span_core.sv @@
// Calendar date span core: top level with an eight-stage pipeline and input skid register.
//
// The input channel carries one date pair and a mode per transfer; tdata holds, from the
// lowest bit up, mode, first_year, first_month, first_day, second_year, second_month and
// second_day, with zero fill up to 56 bits. Every transfer gives exactly one result on the
// output channel: span, was_swapped and start_weekday, from the lowest bit up.
// Months are clamped to 1..12 and days to the month length before the dates are ordered.
// A result appears on m_tvalid after the stage registers 1 to 7 and the output register,
// and a new pair is accepted on every cycle unless the receiver stalls. The rate is set by
// the pipeline, which advances as one unit whenever the output register is empty or taken;
// division by seven or one hundred is a reciprocal product, by seven in its own stage.
// When the receiver stalls, the pipeline holds its contents and a one-entry skid register
// takes the transfer that s_tready had already promised; s_tready is a register output.
// A synchronous low aresetn empties the pipeline, the skid register and the output.
`default_nettype none
`include "calendar_date_span_core_assert.svh"

module calendar_date_span_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // mode, first_year, first_month, first_day, second_year, second_month, second_day
    input  wire logic [cds_pkg::S_TDATA_W-1:0] s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // span, was_swapped, start_weekday
    output      logic [cds_pkg::M_TDATA_W-1:0] m_tdata
);
    import cds_pkg::*;

    logic                 pipe_en;
    logic                 s_accept;
    logic                 skid_valid_reg;
    logic [IN_BITS-1:0]   skid_data_reg;
    logic                 in_valid;
    logic [IN_BITS-1:0]   in_data;

    logic [MODE_W-1:0]    in_mode;
    logic [YEAR_W-1:0]    in_y1, in_y2;
    logic [MONTH_W-1:0]   in_m1, in_m2, in_m1c, in_m2c;
    logic [26:0]          in_p1, in_p2;

    logic                 s1_valid_reg;
    logic [MODE_W-1:0]    s1_mode_reg;
    logic [YEAR_W-1:0]    s1_y1_reg, s1_y2_reg;
    logic [MONTH_W-1:0]   s1_m1_reg, s1_m2_reg;
    logic [DAY_W-1:0]     s1_d1_reg, s1_d2_reg;
    logic [7:0]           s1_q1_reg, s1_q2_reg;

    logic [YEAR_W-1:0]    s2_r1, s2_r2;
    logic                 s2_leap1, s2_leap2;
    logic [DAY_W-1:0]     s2_len1, s2_len2, s2_d1c, s2_d2c;
    logic                 s2_swap;
    logic [YEAR_W-1:0]    s2_ya_next, s2_yb_next;
    logic [MONTH_W-1:0]   s2_ma_next, s2_mb_next;
    logic [DAY_W-1:0]     s2_da_next, s2_db_next;

    logic                 s2_valid_reg;
    logic [MODE_W-1:0]    s2_mode_reg;
    logic                 s2_swap_reg;
    logic [YEAR_W-1:0]    s2_ya_reg, s2_yb_reg;
    logic [MONTH_W-1:0]   s2_ma_reg, s2_mb_reg;
    logic [DAY_W-1:0]     s2_da_reg, s2_db_reg;

    logic [YY_W-1:0]      s3_yya_next, s3_yyb_next;
    logic [27:0]          s3_pa, s3_pb;
    logic [YEAR_W-1:0]    s3_ydiff;
    logic [18:0]          s3_months;
    logic [YEAR_W-1:0]    s3_years;
    logic                 s3_mon_inc, s3_year_inc;

    logic                 s3_valid_reg;
    logic [MODE_W-1:0]    s3_mode_reg;
    logic                 s3_swap_reg;
    logic [YY_W-1:0]      s3_yya_reg, s3_yyb_reg;
    logic [8:0]           s3_qa_reg, s3_qb_reg;
    logic [MTERM_W-1:0]   s3_mta_reg, s3_mtb_reg;
    logic [DAY_W-1:0]     s3_da_reg, s3_db_reg;
    logic [17:0]          s3_months_reg;
    logic [YEAR_W-1:0]    s3_years_reg;

    logic [23:0]          s4_na, s4_nb;
    logic                 s4_valid_reg;
    logic [MODE_W-1:0]    s4_mode_reg;
    logic                 s4_swap_reg;
    logic [DN_W-1:0]      s4_na_reg, s4_nb_reg;
    logic [17:0]          s4_months_reg;
    logic [YEAR_W-1:0]    s4_years_reg;

    logic                 s5_valid_reg;
    logic [MODE_W-1:0]    s5_mode_reg;
    logic                 s5_swap_reg;
    logic [DN_W-1:0]      s5_diff_reg, s5_nw_reg;
    logic [17:0]          s5_months_reg;
    logic [YEAR_W-1:0]    s5_years_reg;

    logic [46:0]          s6_pd, s6_pw;
    logic                 s6_valid_reg;
    logic [MODE_W-1:0]    s6_mode_reg;
    logic                 s6_swap_reg;
    logic [DN_W-1:0]      s6_diff_reg, s6_nw_reg;
    logic [20:0]          s6_qd_reg, s6_qw_reg;
    logic [17:0]          s6_months_reg;
    logic [YEAR_W-1:0]    s6_years_reg;

    logic [DN_W-1:0]      s7_rd_full, s7_wd_full;
    logic                 s7_valid_reg;
    logic [MODE_W-1:0]    s7_mode_reg;
    logic                 s7_swap_reg;
    logic [DN_W-1:0]      s7_diff_reg;
    logic [20:0]          s7_qd_reg;
    logic [2:0]           s7_rd_reg;
    logic [WD_W-1:0]      s7_wd_reg;
    logic [17:0]          s7_months_reg;
    logic [YEAR_W-1:0]    s7_years_reg;

    logic [20:0]          s8_tq;
    logic [2:0]           s8_rest;
    logic [23:0]          s8_full;
    logic [SPAN_W-1:0]    s8_span;

    logic                 m_tvalid_reg;
    logic [SPAN_W-1:0]    out_span_reg;
    logic                 out_swap_reg;
    logic [WD_W-1:0]      out_wd_reg;

    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign in_valid = skid_valid_reg || s_tvalid;
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata[IN_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
        if (!pipe_en && s_accept) begin
            skid_data_reg <= s_tdata[IN_BITS-1:0];
        end
    end

    // Stage 1: clamp months and start the division of each year by one hundred.
    always_comb begin
        in_mode = in_data[2:0];
        in_y1   = in_data[16:3];
        in_m1   = in_data[20:17];
        in_y2   = in_data[39:26];
        in_m2   = in_data[43:40];
        in_m1c  = (in_m1 == 4'd0) ? 4'd1 : ((in_m1 > 4'd12) ? 4'd12 : in_m1);
        in_m2c  = (in_m2 == 4'd0) ? 4'd1 : ((in_m2 > 4'd12) ? 4'd12 : in_m2);
        in_p1   = 27'(in_y1) * 27'(RECIP100);
        in_p2   = 27'(in_y2) * 27'(RECIP100);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= in_valid;
        end
        if (pipe_en) begin
            s1_mode_reg <= in_mode;
            s1_y1_reg   <= in_y1;
            s1_y2_reg   <= in_y2;
            s1_m1_reg   <= in_m1c;
            s1_m2_reg   <= in_m2c;
            s1_d1_reg   <= in_data[25:21];
            s1_d2_reg   <= in_data[48:44];
            s1_q1_reg   <= in_p1[26:RECIP100_SH];
            s1_q2_reg   <= in_p2[26:RECIP100_SH];
        end
    end

    // Stage 2: leap years, day clamp, ordering of the two dates.
    always_comb begin
        s2_r1    = s1_y1_reg - 14'(s1_q1_reg) * 14'(100);
        s2_r2    = s1_y2_reg - 14'(s1_q2_reg) * 14'(100);
        s2_leap1 = (s1_y1_reg[1:0] == 2'd0) && ((s2_r1 != '0) || (s1_q1_reg[1:0] == 2'd0));
        s2_leap2 = (s1_y2_reg[1:0] == 2'd0) && ((s2_r2 != '0) || (s1_q2_reg[1:0] == 2'd0));
        s2_len1  = month_len(s1_m1_reg, s2_leap1);
        s2_len2  = month_len(s1_m2_reg, s2_leap2);
        s2_d1c   = (s1_d1_reg == '0) ? 5'd1 : ((s1_d1_reg > s2_len1) ? s2_len1 : s1_d1_reg);
        s2_d2c   = (s1_d2_reg == '0) ? 5'd1 : ((s1_d2_reg > s2_len2) ? s2_len2 : s1_d2_reg);
        s2_swap  = {s1_y2_reg, s1_m2_reg, s2_d2c} < {s1_y1_reg, s1_m1_reg, s2_d1c};
        s2_ya_next = s2_swap ? s1_y2_reg : s1_y1_reg;
        s2_ma_next = s2_swap ? s1_m2_reg : s1_m1_reg;
        s2_da_next = s2_swap ? s2_d2c    : s2_d1c;
        s2_yb_next = s2_swap ? s1_y1_reg : s1_y2_reg;
        s2_mb_next = s2_swap ? s1_m1_reg : s1_m2_reg;
        s2_db_next = s2_swap ? s2_d1c    : s2_d2c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (pipe_en) begin
            s2_mode_reg <= s1_mode_reg;
            s2_swap_reg <= s2_swap;
            s2_ya_reg   <= s2_ya_next;
            s2_ma_reg   <= s2_ma_next;
            s2_da_reg   <= s2_da_next;
            s2_yb_reg   <= s2_yb_next;
            s2_mb_reg   <= s2_mb_next;
            s2_db_reg   <= s2_db_next;
        end
    end

    // Stage 3: March-based years, their division by one hundred, month and year counts.
    always_comb begin
        s3_yya_next = 15'(s2_ya_reg) + 15'(YEAR_OFFSET) - 15'(s2_ma_reg <= 4'd2);
        s3_yyb_next = 15'(s2_yb_reg) + 15'(YEAR_OFFSET) - 15'(s2_mb_reg <= 4'd2);
        s3_pa       = 28'(s3_yya_next) * 28'(RECIP100);
        s3_pb       = 28'(s3_yyb_next) * 28'(RECIP100);
        s3_ydiff    = s2_yb_reg - s2_ya_reg;
        s3_mon_inc  = s2_da_reg <= s2_db_reg;
        s3_year_inc = (s2_mb_reg > s2_ma_reg) ||
                      ((s2_mb_reg == s2_ma_reg) && (s2_db_reg >= s2_da_reg));
        s3_months   = 19'(s3_ydiff) * 19'(12) + 19'(s2_mb_reg) - 19'(s2_ma_reg)
                      - 19'd1 + 19'(s3_mon_inc);
        s3_years    = s3_ydiff - 14'd1 + 14'(s3_year_inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (pipe_en) begin
            s3_mode_reg   <= s2_mode_reg;
            s3_swap_reg   <= s2_swap_reg;
            s3_yya_reg    <= s3_yya_next;
            s3_yyb_reg    <= s3_yyb_next;
            s3_qa_reg     <= s3_pa[27:RECIP100_SH];
            s3_qb_reg     <= s3_pb[27:RECIP100_SH];
            s3_mta_reg    <= month_offset(s2_ma_reg);
            s3_mtb_reg    <= month_offset(s2_mb_reg);
            s3_da_reg     <= s2_da_reg;
            s3_db_reg     <= s2_db_reg;
            s3_months_reg <= s3_months[17:0];
            s3_years_reg  <= s3_years;
        end
    end

    // Stage 4: day numbers of both dates.
    always_comb begin
        s4_na = 24'(s3_yya_reg) * 24'(365) + 24'(s3_yya_reg >> 2) - 24'(s3_qa_reg)
                + 24'(s3_qa_reg >> 2) + 24'(s3_mta_reg) + 24'(s3_da_reg) - 24'd1;
        s4_nb = 24'(s3_yyb_reg) * 24'(365) + 24'(s3_yyb_reg >> 2) - 24'(s3_qb_reg)
                + 24'(s3_qb_reg >> 2) + 24'(s3_mtb_reg) + 24'(s3_db_reg) - 24'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s4_valid_reg <= s3_valid_reg;
        end
        if (pipe_en) begin
            s4_mode_reg   <= s3_mode_reg;
            s4_swap_reg   <= s3_swap_reg;
            s4_na_reg     <= s4_na[DN_W-1:0];
            s4_nb_reg     <= s4_nb[DN_W-1:0];
            s4_months_reg <= s3_months_reg;
            s4_years_reg  <= s3_years_reg;
        end
    end

    // Stage 5: difference of day numbers and the weekday offset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s5_valid_reg <= s4_valid_reg;
        end
        if (pipe_en) begin
            s5_mode_reg   <= s4_mode_reg;
            s5_swap_reg   <= s4_swap_reg;
            s5_diff_reg   <= s4_nb_reg - s4_na_reg;
            s5_nw_reg     <= s4_na_reg + 23'd2;
            s5_months_reg <= s4_months_reg;
            s5_years_reg  <= s4_years_reg;
        end
    end

    // Stage 6: division by seven through the reciprocal.
    always_comb begin
        s6_pd = 47'(s5_diff_reg) * 47'(RECIP7);
        s6_pw = 47'(s5_nw_reg) * 47'(RECIP7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s6_valid_reg <= s5_valid_reg;
        end
        if (pipe_en) begin
            s6_mode_reg   <= s5_mode_reg;
            s6_swap_reg   <= s5_swap_reg;
            s6_diff_reg   <= s5_diff_reg;
            s6_nw_reg     <= s5_nw_reg;
            s6_qd_reg     <= s6_pd[46:RECIP7_SH];
            s6_qw_reg     <= s6_pw[46:RECIP7_SH];
            s6_months_reg <= s5_months_reg;
            s6_years_reg  <= s5_years_reg;
        end
    end

    // Stage 7: remainders by seven, which give the weekday and the partial week.
    always_comb begin
        s7_rd_full = s6_diff_reg - 23'(s6_qd_reg) * 23'(7);
        s7_wd_full = s6_nw_reg - 23'(s6_qw_reg) * 23'(7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s7_valid_reg <= s6_valid_reg;
        end
        if (pipe_en) begin
            s7_mode_reg   <= s6_mode_reg;
            s7_swap_reg   <= s6_swap_reg;
            s7_diff_reg   <= s6_diff_reg;
            s7_qd_reg     <= s6_qd_reg;
            s7_rd_reg     <= s7_rd_full[2:0];
            s7_wd_reg     <= s7_wd_full[WD_W-1:0];
            s7_months_reg <= s6_months_reg;
            s7_years_reg  <= s6_years_reg;
        end
    end

    // Stage 8: select the count by mode and saturate it.
    always_comb begin
        s8_tq   = s7_qd_reg + 21'(s7_rd_reg == 3'd6);
        s8_rest = (s7_rd_reg == 3'd6) ? 3'd0 : s7_rd_reg + 3'd1;
        case (s7_mode_reg)
            MODE_DAYS:      s8_full = 24'(s7_diff_reg);
            MODE_INCL_DAYS: s8_full = 24'(s7_diff_reg) + 24'd1;
            MODE_WEEKS:     s8_full = 24'(s7_qd_reg);
            MODE_MONTHS:    s8_full = 24'(s7_months_reg);
            MODE_YEARS:     s8_full = 24'(s7_years_reg);
            MODE_WORK_DAYS: s8_full = 24'(s8_tq) * 24'(5)
                                      + 24'(work_partial(s7_wd_reg, s8_rest));
            default:        s8_full = 24'd0;
        endcase
        s8_span = (s8_full > 24'(SPAN_MAX)) ? SPAN_W'(SPAN_MAX) : s8_full[SPAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_tvalid_reg <= s7_valid_reg;
        end
        if (pipe_en) begin
            out_span_reg <= s8_span;
            out_swap_reg <= s7_swap_reg;
            out_wd_reg   <= s7_wd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_wd_reg, out_swap_reg, out_span_reg};

    `CDS_ASSERT_NXT(skid_hold_a, skid_valid_reg && !pipe_en, skid_valid_reg,
        "Skid register lost a transfer during a stall.")
    `CDS_ASSERT_NXT(out_load_a, s7_valid_reg && pipe_en, m_tvalid_reg,
        "Last pipeline stage did not reach the output register.")
    `CDS_ASSERT_IMP(order_a, s2_valid_reg,
        ({s2_ya_reg, s2_ma_reg, s2_da_reg} <= {s2_yb_reg, s2_mb_reg, s2_db_reg}),
        "Dates leave the ordering stage out of order.")
    `CDS_ASSERT_IMP(weekday_a, m_tvalid_reg, out_wd_reg != 3'd7,
        "Start weekday is out of range.")

endmodule

`default_nettype wire
